// ===== src/rcm_pkg.sv =====
// Shared types, codes and helper functions of the resize coordinate mapper.
package rcm_pkg;

  localparam int unsigned MaxCoordBits = 24;
  localparam int unsigned InBits       = 16;
  localparam int unsigned DivBits      = 34;
  localparam int unsigned CfgDataBits  = 24;

  localparam logic [2:0] REG_TRANSFORM  = 3'd0;
  localparam logic [2:0] REG_ROUNDING   = 3'd1;
  localparam logic [2:0] REG_SCALE      = 3'd2;
  localparam logic [2:0] REG_RESIZED    = 3'd3;
  localparam logic [2:0] REG_SOURCE     = 3'd4;
  localparam logic [2:0] REG_ROI_START  = 3'd5;
  localparam logic [2:0] REG_ROI_END    = 3'd6;
  localparam logic [2:0] REG_DOWNSAMPLE = 3'd7;

  localparam logic [2:0] XF_ASYMMETRIC   = 3'd0;
  localparam logic [2:0] XF_PYTORCH_HALF = 3'd1;
  localparam logic [2:0] XF_TF_HALF_NN   = 3'd2;
  localparam logic [2:0] XF_ALIGN        = 3'd3;
  localparam logic [2:0] XF_CROP         = 3'd4;
  localparam logic [2:0] XF_HALF_PIXEL   = 3'd5;

  localparam logic [2:0] RND_PREFER_FLOOR = 3'd0;
  localparam logic [2:0] RND_PREFER_CEIL  = 3'd1;
  localparam logic [2:0] RND_FLOOR        = 3'd2;
  localparam logic [2:0] RND_CEIL         = 3'd3;
  localparam logic [2:0] RND_LEGACY       = 3'd4;

  typedef struct packed {
    logic [2:0]         transform_mode;
    logic [2:0]         rounding_mode;
    logic [23:0]        scale_factor;
    logic [16:0]        resized_length;
    logic [16:0]        source_length;
    logic signed [17:0] region_start;
    logic signed [17:0] region_end;
    logic               downsampling;
  } rcm_cfg_t;

  typedef struct packed {
    logic sat_lo;
    logic sat_hi;
  } rcm_flags_t;

  // Positive divisor of the mapping; it depends on the registers only.
  function automatic logic [DivBits-1:0] rcm_divisor(rcm_cfg_t cfg);
    logic [23:0]        s_eff;
    logic [DivBits-1:0] d;
    logic               long_axis;
    s_eff     = (cfg.scale_factor == 24'd0) ? 24'd1 : cfg.scale_factor;
    long_axis = (cfg.resized_length > 17'd1);
    case (cfg.transform_mode)
      XF_ASYMMETRIC: d = DivBits'(s_eff);
      XF_PYTORCH_HALF: d = long_axis ? (DivBits'(s_eff) << 1) : DivBits'(1);
      XF_TF_HALF_NN: d = DivBits'(s_eff) << 1;
      XF_ALIGN: d = long_axis ? DivBits'(cfg.resized_length - 17'd1) : DivBits'(1);
      XF_CROP: begin
        d = long_axis ? (DivBits'(cfg.resized_length - 17'd1) << 16)
                      : (DivBits'(2) << 16);
      end
      default: d = DivBits'(s_eff) << 1;
    endcase
    return d;
  endfunction

endpackage

// ===== src/rcm_stream_if.sv =====
// Valid/ready stream interfaces for coordinate beats and result beats.
interface rcm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_coord;

  modport source (output valid, output out_coord, input ready);
  modport sink (input valid, input out_coord, output ready);
endinterface

interface rcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] source_coord;
  logic signed [20:0] nearest_index;
  logic               saturated;

  modport source (output valid, output source_coord, output nearest_index,
                  output saturated, input ready);
  modport sink (input valid, input source_coord, input nearest_index,
                input saturated, output ready);
endinterface

// ===== src/resize_coordinate_mapper.sv =====
// Throughput: one beat per cycle when the output is not stalled; the long
// divider is one stage per quotient bit.
// The whole pipeline holds together when the output register is full and not taken.
// Reset is asynchronous and active low; it clears valid bits and restores the
// register defaults (half pixel transform, round prefer floor, unit scale).
module resize_coordinate_mapper #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rcm_in_if.sink                         in_i,
  rcm_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [rcm_pkg::CfgDataBits-1:0] cfg_data_i
);
  import rcm_pkg::*;

  // Quotient bits above the binary point, with a guard band around the
  // saturation limits of both results.
  localparam int unsigned QI = ((31 - FRAC_BITS > 20) ? 31 - FRAC_BITS : 20) + 2;
  // Total quotient bits: integer part with offset, plus one extra fraction
  // bit that decides round-to-nearest of the coordinate.
  localparam int unsigned QB = QI + FRAC_BITS + 2;

  rcm_cfg_t               cfg_q;
  logic [DivBits-1:0]     divisor;
  logic                   en;
  logic [MaxCoordBits-1:0] x_ext;

  logic                   v_a     [QB+1];
  rcm_flags_t             flags_a [QB+1];
  logic [DivBits-1:0]     rem_a   [QB+1];
  logic [QB-1:0]          mlo_a   [QB+1];
  logic [QB-1:0]          quo_a   [QB+1];

  // Register file. Writes must arrive only while no beat is in flight; the block
  // does not enforce this. Every pipeline stage reads the registers directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.transform_mode <= XF_HALF_PIXEL;
      cfg_q.rounding_mode  <= RND_PREFER_FLOOR;
      cfg_q.scale_factor   <= 24'd65536;
      cfg_q.resized_length <= 17'd1;
      cfg_q.source_length  <= 17'd1;
      cfg_q.region_start   <= 18'sd0;
      cfg_q.region_end     <= 18'sd65536;
      cfg_q.downsampling   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRANSFORM:  cfg_q.transform_mode <= cfg_data_i[2:0];
        REG_ROUNDING:   cfg_q.rounding_mode  <= cfg_data_i[2:0];
        REG_SCALE:      cfg_q.scale_factor   <= cfg_data_i[23:0];
        REG_RESIZED:    cfg_q.resized_length <= cfg_data_i[16:0];
        REG_SOURCE:     cfg_q.source_length  <= cfg_data_i[16:0];
        REG_ROI_START:  cfg_q.region_start   <= $signed(cfg_data_i[17:0]);
        REG_ROI_END:    cfg_q.region_end     <= $signed(cfg_data_i[17:0]);
        REG_DOWNSAMPLE: cfg_q.downsampling   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The divisor depends on the registers alone and is shared by every step.
  assign divisor = rcm_divisor(cfg_q);

  // Only the low COORD_BITS bits of the coordinate take part.
  assign x_ext    = MaxCoordBits'(in_i.out_coord);
  assign in_i.ready = en;

  // Three front stages: two multiplier levels, then the numerator mux with
  // the offset that makes an in-range quotient nonnegative.
  rcm_prep #(
    .CoordBits (COORD_BITS),
    .FracBits  (FRAC_BITS),
    .QiBits    (QI),
    .QuoBits   (QB)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .x_i     (x_ext[COORD_BITS-1:0]),
    .cfg_i   (cfg_q),
    .d_i     (divisor),
    .valid_o (v_a[0]),
    .flags_o (flags_a[0]),
    .rem_o   (rem_a[0]),
    .mlo_o   (mlo_a[0]),
    .quo_o   (quo_a[0])
  );

  // One restoring step per quotient bit; the fraction bits come from the
  // zeros that shift in below the numerator.
  for (genvar g = 0; g < QB; g++) begin : g_div
    rcm_div_stage #(
      .QuoBits (QB)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .d_i     (divisor),
      .valid_i (v_a[g]),
      .flags_i (flags_a[g]),
      .rem_i   (rem_a[g]),
      .mlo_i   (mlo_a[g]),
      .quo_i   (quo_a[g]),
      .valid_o (v_a[g+1]),
      .flags_o (flags_a[g+1]),
      .rem_o   (rem_a[g+1]),
      .mlo_o   (mlo_a[g+1]),
      .quo_o   (quo_a[g+1])
    );
  end

  // Rounding, saturation and the output register; it also sets the global
  // advance enable, so a stall freezes every stage together.
  rcm_finish #(
    .FracBits (FRAC_BITS),
    .QiBits   (QI),
    .QuoBits  (QB)
  ) u_finish (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_o            (en),
    .valid_i         (v_a[QB]),
    .flags_i         (flags_a[QB]),
    .rem_i           (rem_a[QB]),
    .quo_i           (quo_a[QB]),
    .rounding_mode_i (cfg_q.rounding_mode),
    .downsampling_i  (cfg_q.downsampling),
    .out_o           (out_o)
  );

endmodule

// ===== src/rcm_prep.sv =====
// Front stages: products, numerator selection and range check of the quotient.
module rcm_prep #(
  parameter int unsigned CoordBits = 16,
  parameter int unsigned FracBits  = 16,
  parameter int unsigned QiBits    = 22,
  parameter int unsigned QuoBits   = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [CoordBits-1:0]           x_i,
  input  rcm_pkg::rcm_cfg_t              cfg_i,
  input  logic [rcm_pkg::DivBits-1:0]    d_i,
  output logic                           valid_o,
  output rcm_pkg::rcm_flags_t            flags_o,
  output logic [rcm_pkg::DivBits-1:0]    rem_o,
  output logic [QuoBits-1:0]             mlo_o,
  output logic [QuoBits-1:0]             quo_o
);
  import rcm_pkg::*;

  localparam int unsigned NW = ((CoordBits + 38 > 54) ? CoordBits + 38 : 54) + 1;
  localparam int unsigned MW = ((NW > DivBits + QiBits + 2) ? NW : DivBits + QiBits + 2) + 1;

  logic signed [CoordBits:0]    xs;
  logic signed [18:0]           rdiff, rsum;
  logic signed [17:0]           ls1, lrm1;

  logic                         v1_q, v2_q, v3_q;
  logic signed [CoordBits:0]    x1_q, x2_q;
  logic signed [CoordBits+19:0] p1_q;
  logic signed [35:0]           b1_q;
  logic signed [CoordBits+18:0] xl1_q, xl2_q;
  logic signed [36:0]           e1_q, e2_q;
  logic signed [CoordBits+37:0] p2_q;
  logic signed [53:0]           b2_q;

  logic signed [NW-1:0]         n, x_n, s_n, half_n;
  logic signed [MW-1:0]         m, d_m;
  logic                         long_axis;
  logic [23:0]                  s_eff;

  rcm_flags_t                   flags_q;
  logic [DivBits-1:0]           rem_q;
  logic [QuoBits-1:0]           mlo_q;

  assign xs    = $signed({1'b0, x_i});
  assign rdiff = $signed({cfg_i.region_end[17], cfg_i.region_end})
               - $signed({cfg_i.region_start[17], cfg_i.region_start});
  assign rsum  = $signed({cfg_i.region_end[17], cfg_i.region_end})
               + $signed({cfg_i.region_start[17], cfg_i.region_start});
  assign ls1   = $signed({1'b0, cfg_i.source_length}) - 18'sd1;
  assign lrm1  = $signed({1'b0, 17'(cfg_i.resized_length - 17'd1)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // First and second multiplier stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= xs;
      p1_q  <= xs * rdiff;
      b1_q  <= cfg_i.region_start * ls1;
      xl1_q <= xs * ls1;
      e1_q  <= rsum * ls1;
      x2_q  <= x1_q;
      p2_q  <= p1_q * ls1;
      b2_q  <= b1_q * lrm1;
      xl2_q <= xl1_q;
      e2_q  <= e1_q;
    end
  end

  assign long_axis = (cfg_i.resized_length > 17'd1);
  assign s_eff     = (cfg_i.scale_factor == 24'd0) ? 24'd1 : cfg_i.scale_factor;
  assign x_n       = NW'(x2_q);
  assign s_n       = NW'($signed({1'b0, s_eff}));
  assign half_n    = (x_n <<< 17) + NW'(65536) - s_n;

  always_comb begin
    case (cfg_i.transform_mode)
      XF_ASYMMETRIC:   n = x_n <<< 16;
      XF_PYTORCH_HALF: n = long_axis ? half_n : '0;
      XF_TF_HALF_NN:   n = (x_n <<< 17) + NW'(65536);
      XF_ALIGN:        n = long_axis ? NW'(xl2_q) : '0;
      XF_CROP:         n = long_axis ? (NW'(p2_q) + NW'(b2_q)) : NW'(e2_q);
      default:         n = half_n;
    endcase
  end

  // Offset the numerator so a quotient in range becomes a nonnegative one.
  assign d_m = MW'($signed({1'b0, d_i}));
  assign m   = MW'(n) + (d_m <<< QiBits);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q.sat_lo <= m[MW-1];
      flags_q.sat_hi <= (m >= (d_m <<< (QiBits + 1)));
      rem_q          <= m[QiBits+DivBits:QiBits+1];
      mlo_q          <= {m[QiBits:0], {(FracBits+1){1'b0}}};
    end
  end

  assign valid_o = v3_q;
  assign flags_o = flags_q;
  assign rem_o   = rem_q;
  assign mlo_o   = mlo_q;
  assign quo_o   = '0;

endmodule

// ===== src/rcm_div_stage.sv =====
// One restoring division step with its pipeline register.
module rcm_div_stage #(
  parameter int unsigned QuoBits = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [rcm_pkg::DivBits-1:0]  d_i,
  input  logic                         valid_i,
  input  rcm_pkg::rcm_flags_t          flags_i,
  input  logic [rcm_pkg::DivBits-1:0]  rem_i,
  input  logic [QuoBits-1:0]           mlo_i,
  input  logic [QuoBits-1:0]           quo_i,
  output logic                         valid_o,
  output rcm_pkg::rcm_flags_t          flags_o,
  output logic [rcm_pkg::DivBits-1:0]  rem_o,
  output logic [QuoBits-1:0]           mlo_o,
  output logic [QuoBits-1:0]           quo_o
);
  import rcm_pkg::*;

  logic [DivBits:0]   trial;
  logic               take;
  logic               valid_q;
  rcm_flags_t         flags_q;
  logic [DivBits-1:0] rem_q;
  logic [QuoBits-1:0] mlo_q, quo_q;

  assign trial = {rem_i, mlo_i[QuoBits-1]};
  assign take  = (trial >= {1'b0, d_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_i;
      rem_q   <= take ? DivBits'(trial - {1'b0, d_i}) : DivBits'(trial);
      mlo_q   <= {mlo_i[QuoBits-2:0], 1'b0};
      quo_q   <= {quo_i[QuoBits-2:0], take};
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign rem_o   = rem_q;
  assign mlo_o   = mlo_q;
  assign quo_o   = quo_q;

endmodule

// ===== src/rcm_finish.sv =====
// Final stage: fixed-point coordinate, index rounding, saturation and output register.
module rcm_finish #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned QiBits   = 22,
  parameter int unsigned QuoBits  = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  output logic                         en_o,
  input  logic                         valid_i,
  input  rcm_pkg::rcm_flags_t          flags_i,
  input  logic [rcm_pkg::DivBits-1:0]  rem_i,
  input  logic [QuoBits-1:0]           quo_i,
  input  logic [2:0]                   rounding_mode_i,
  input  logic                         downsampling_i,
  rcm_out_if.source                    out_o
);
  import rcm_pkg::*;

  localparam int unsigned CW = QiBits + FracBits + 2;
  localparam int unsigned IW = QiBits + 2;
  localparam logic signed [QiBits:0] Lim    = (QiBits+1)'(64'sd1 <<< (31 - FracBits));
  localparam logic signed [CW-1:0]   CMax   = CW'(64'sd2147483647);
  localparam logic signed [CW-1:0]   CMin   = CW'(-64'sd2147483648);
  localparam logic signed [IW-1:0]   IMax   = IW'(1048575);
  localparam logic signed [IW-1:0]   IMin   = IW'(-1048576);

  logic signed [QiBits:0] q;
  logic [FracBits:0]      f2;
  logic [FracBits+1:0]    f2_inc;
  logic [FracBits:0]      fq;
  logic signed [CW-1:0]   coord_full;
  logic                   rnz, half_ge, half_gt;
  logic signed [IW-1:0]   q_i, idx;
  logic signed [31:0]     coord;
  logic signed [20:0]     nidx;
  logic                   sat_c, sat_i;

  logic                   valid_q;
  logic signed [31:0]     coord_q;
  logic signed [20:0]     idx_q;
  logic                   sat_q;

  // The quotient carries an offset of 2**QiBits; flipping the top bit removes it.
  assign q          = $signed({~quo_i[QuoBits-1], quo_i[QuoBits-2:FracBits+1]});
  assign f2         = quo_i[FracBits:0];
  assign f2_inc     = {1'b0, f2} + (FracBits+2)'(1);
  assign fq         = f2_inc[FracBits+1:1];
  assign coord_full = (CW'(q) <<< FracBits) + CW'($signed({1'b0, fq}));
  assign rnz        = (f2 != '0) || (rem_i != '0);
  assign half_ge    = f2[FracBits];
  assign half_gt    = f2[FracBits] && ((f2[FracBits-1:0] != '0) || (rem_i != '0));
  assign q_i        = IW'(q);

  always_comb begin
    case (rounding_mode_i)
      RND_FLOOR:       idx = q_i;
      RND_CEIL:        idx = q_i + IW'(rnz);
      RND_LEGACY: begin
        if (downsampling_i) begin
          idx = q_i + IW'(rnz);
        end else begin
          idx = q_i + IW'(q_i[IW-1] && rnz);
        end
      end
      RND_PREFER_CEIL: idx = q_i + IW'(half_ge);
      default:         idx = q_i + IW'(half_gt);
    endcase
  end

  always_comb begin
    sat_c = 1'b1;
    sat_i = 1'b1;
    if (flags_i.sat_lo) begin
      coord = 32'sh80000000;
      nidx  = 21'sh100000;
    end else if (flags_i.sat_hi) begin
      coord = 32'sh7FFFFFFF;
      nidx  = 21'sh0FFFFF;
    end else begin
      if (q >= Lim) begin
        coord = 32'sh7FFFFFFF;
      end else if (q < -Lim) begin
        coord = 32'sh80000000;
      end else if (coord_full > CMax) begin
        coord = 32'sh7FFFFFFF;
      end else if (coord_full < CMin) begin
        coord = 32'sh80000000;
      end else begin
        coord = coord_full[31:0];
        sat_c = 1'b0;
      end
      if (idx > IMax) begin
        nidx = 21'sh0FFFFF;
      end else if (idx < IMin) begin
        nidx = 21'sh100000;
      end else begin
        nidx  = idx[20:0];
        sat_i = 1'b0;
      end
    end
  end

  assign en_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      coord_q <= coord;
      idx_q   <= nidx;
      sat_q   <= sat_c || sat_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.source_coord  = coord_q;
  assign out_o.nearest_index = idx_q;
  assign out_o.saturated     = sat_q;

endmodule

// ===== src/rcm_checker.sv =====
// Port-level checks of the resize coordinate mapper and their bind.
module rcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] source_coord_i,
  input logic [20:0] nearest_index_i,
  input logic        saturated_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(source_coord_i) &&
    $stable(nearest_index_i) && $stable(saturated_i))
    else $error("result beat changed while stalled");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input blocked with the output free");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while the pipeline is frozen");

endmodule

bind resize_coordinate_mapper rcm_checker u_rcm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .source_coord_i  (out_o.source_coord),
  .nearest_index_i (out_o.nearest_index),
  .saturated_i     (out_o.saturated)
);

// ===== tb/sv/resize_coordinate_mapper_tb.sv =====
// Self-checking testbench for the resize coordinate mapper.
`timescale 1ns / 1ps

module resize_coordinate_mapper_tb;
  import rcm_pkg::*;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned Latency   = 44;
  localparam longint      CycleCap  = 400000;
  localparam int          RandItems = 950;

  typedef struct packed {
    logic signed [31:0] source_coord;
    logic signed [20:0] nearest_index;
    logic               saturated;
  } mapped_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  rcm_in_if  coord_ch ();
  rcm_out_if result_ch ();

  resize_coordinate_mapper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (coord_ch.sink),
    .out_o      (result_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the mapper's registers, kept in step with every write.
  rcm_cfg_t shadow_cfg;

  logic [15:0]  pending_coords[$];
  mapped_beat_t expected_beats[$];
  int           error_count;
  longint       cycle_count;
  bit           idle_free;   // no idling in the final stretch of the run
  bit           drain_hold;  // long receiver hold-off to back up the pipeline
  int           hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever begin
      #2 clk_i = 1'b1;
      #2 clk_i = 1'b0;
    end
  end

  // Computes the expected beat for one coordinate from the exact rational
  // n/d that each transform defines, then rounds it both ways.
  function automatic mapped_beat_t map_coordinate(rcm_cfg_t c, logic [15:0] coord);
    longint one, x, s, lr, ls1, rs, re, n, d, q, r, idx, fpos, lim, f2;
    bit sat;
    mapped_beat_t b;
    one = 64'sd1 << 16;
    x   = coord;
    s   = (c.scale_factor == 0) ? 1 : c.scale_factor;
    lr  = c.resized_length;
    ls1 = longint'(c.source_length) - 1;
    rs  = c.region_start;
    re  = c.region_end;
    sat = 1'b0;
    case (c.transform_mode)
      XF_ASYMMETRIC: begin
        n = x * one; d = s;
      end
      XF_PYTORCH_HALF: begin
        if (lr > 1) begin
          n = (2 * x + 1) * one - s; d = 2 * s;
        end else begin
          n = 0; d = 1;
        end
      end
      XF_TF_HALF_NN: begin
        n = (2 * x + 1) * one; d = 2 * s;
      end
      XF_ALIGN: begin
        if (lr > 1) begin
          n = x * ls1; d = lr - 1;
        end else begin
          n = 0; d = 1;
        end
      end
      XF_CROP: begin
        if (lr > 1) begin
          n = rs * ls1 * (lr - 1) + x * (re - rs) * ls1; d = (lr - 1) * one;
        end else begin
          n = (rs + re) * ls1; d = 2 * one;
        end
      end
      default: begin
        n = (2 * x + 1) * one - s; d = 2 * s;
      end
    endcase
    // Floor division with a nonnegative remainder.
    q = n / d;
    r = n % d;
    if (r < 0) begin
      q -= 1; r += d;
    end
    lim = 64'sd1 << (31 - FracBits);
    f2  = (r * (64'sd1 << (FracBits + 1))) / d;
    if (q >= lim) begin
      fpos = 64'sd2147483647; sat = 1'b1;
    end else if (q < -lim) begin
      fpos = -64'sd2147483648; sat = 1'b1;
    end else begin
      fpos = q * (64'sd1 << FracBits) + (f2 + 1) / 2;
      if (fpos > 64'sd2147483647) begin
        fpos = 64'sd2147483647; sat = 1'b1;
      end
      if (fpos < -64'sd2147483648) begin
        fpos = -64'sd2147483648; sat = 1'b1;
      end
    end
    case (c.rounding_mode)
      RND_FLOOR: idx = q;
      RND_CEIL: idx = q + ((r != 0) ? 1 : 0);
      RND_LEGACY: begin
        if (c.downsampling) idx = q + ((r != 0) ? 1 : 0);
        else idx = (q < 0 && r != 0) ? q + 1 : q;
      end
      RND_PREFER_CEIL: idx = (2 * r >= d) ? q + 1 : q;
      default: idx = (2 * r > d) ? q + 1 : q;
    endcase
    if (idx > 1048575) begin
      idx = 1048575; sat = 1'b1;
    end
    if (idx < -1048576) begin
      idx = -1048576; sat = 1'b1;
    end
    b.source_coord  = fpos[31:0];
    b.nearest_index = idx[20:0];
    b.saturated     = sat;
    return b;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Register write, applied at one rising edge; the shadow copy follows.
  task automatic write_reg(logic [2:0] idx, logic [CfgDataBits-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_TRANSFORM:  shadow_cfg.transform_mode = val[2:0];
      REG_ROUNDING:   shadow_cfg.rounding_mode  = val[2:0];
      REG_SCALE:      shadow_cfg.scale_factor   = val[23:0];
      REG_RESIZED:    shadow_cfg.resized_length = val[16:0];
      REG_SOURCE:     shadow_cfg.source_length  = val[16:0];
      REG_ROI_START:  shadow_cfg.region_start   = val[17:0];
      REG_ROI_END:    shadow_cfg.region_end     = val[17:0];
      default:        shadow_cfg.downsampling   = val[0];
    endcase
  endtask

  // Waits until the mapper has emptied, then lets its pipeline settle so a
  // register write cannot touch a beat still in flight.
  task automatic wait_idle();
    while (pending_coords.size() != 0 || expected_beats.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Prediction happens at acceptance, so the register values in force at that
  // point are the ones the beat uses.
  task automatic queue_coord(logic [15:0] c);
    pending_coords = {pending_coords, c};
  endtask

  // Input driver: offers queued coordinates with random gap bursts.
  int in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_ch.valid     <= 1'b0;
      coord_ch.out_coord <= '0;
      in_gap             <= 0;
    end else begin
      if (coord_ch.valid && coord_ch.ready) begin
        expected_beats = {expected_beats, map_coordinate(shadow_cfg, coord_ch.out_coord)};
        void'(pending_coords.pop_front());
      end
      if (coord_ch.valid && !coord_ch.ready) begin
        // Hold the offered beat until it is taken.
      end else if (in_gap > 0) begin
        in_gap         <= in_gap - 1;
        coord_ch.valid <= 1'b0;
      end else if (!idle_free && $urandom_range(0, 9) == 0) begin
        in_gap         <= $urandom_range(1, 12) - 1;
        coord_ch.valid <= 1'b0;
      end else begin
        // Offer the next item after the one just taken, if any.
        if (coord_ch.valid && coord_ch.ready) begin
          if (pending_coords.size() > 0) begin
            coord_ch.valid     <= 1'b1;
            coord_ch.out_coord <= pending_coords[0];
          end else begin
            coord_ch.valid <= 1'b0;
          end
        end else if (pending_coords.size() > 0) begin
          coord_ch.valid     <= 1'b1;
          coord_ch.out_coord <= pending_coords[0];
        end
      end
    end
  end

  // Output monitor: random stall bursts, plus one long hold-off.
  int out_gap;
  mapped_beat_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      out_gap         <= 0;
      hold_cycles     <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", result_ch.source_coord, 0);
        end else begin
          want = expected_beats.pop_front();
          if (result_ch.source_coord !== want.source_coord)
            report_mismatch("source_coord", result_ch.source_coord, want.source_coord);
          if (result_ch.nearest_index !== want.nearest_index)
            report_mismatch("nearest_index", result_ch.nearest_index,
                            want.nearest_index);
          if (result_ch.saturated !== want.saturated)
            report_mismatch("saturated", result_ch.saturated, want.saturated);
        end
      end
      if (drain_hold && hold_cycles < 200) begin
        hold_cycles     <= hold_cycles + 1;
        result_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap         <= out_gap - 1;
        result_ch.ready <= 1'b0;
      end else if (!idle_free && $urandom_range(0, 9) == 0) begin
        out_gap         <= $urandom_range(1, 12) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("[resize_coordinate_mapper] ERROR");
      $finish;
    end
  end

  // Picks a random configuration, leaning toward modes that keep the index in
  // range but still reaching the saturating corners now and then.
  task automatic random_setup();
    write_reg(REG_TRANSFORM, $urandom_range(0, 7));
    write_reg(REG_ROUNDING, $urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: write_reg(REG_SCALE, $urandom_range(0, 24'hFFFFFF));
      1: write_reg(REG_SCALE, $urandom_range(0, 15));
      default: write_reg(REG_SCALE, $urandom_range(16384, 262144));
    endcase
    write_reg(REG_RESIZED, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 17'h1FFFF));
    write_reg(REG_SOURCE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 17'h1FFFF));
    write_reg(REG_ROI_START, $urandom_range(0, 18'h3FFFF));
    write_reg(REG_ROI_END, $urandom_range(0, 18'h3FFFF));
    write_reg(REG_DOWNSAMPLE, $urandom_range(0, 1));
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_TRANSFORM;
    cfg_data_i  = '0;
    error_count = 0;
    cycle_count = 0;
    idle_free   = 1'b0;
    drain_hold  = 1'b0;
    shadow_cfg  = '{transform_mode: XF_HALF_PIXEL, rounding_mode: RND_PREFER_FLOOR,
                    scale_factor: 24'd65536, resized_length: 17'd1,
                    source_length: 17'd1, region_start: 18'sd0,
                    region_end: 18'sd65536, downsampling: 1'b0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values first, with the coordinate extremes and two alternating bit patterns.
    queue_coord(16'd0);
    queue_coord(16'hFFFF);
    queue_coord(16'h5555);
    queue_coord(16'hAAAA);
    wait_idle();

    // Every transform code, each with the rounding code of the same number, on a
    // half-scale axis where ties land exactly; the unused codes are covered too.
    write_reg(REG_SCALE, 24'd131072);
    write_reg(REG_RESIZED, 17'd8);
    write_reg(REG_SOURCE, 17'd4);
    write_reg(REG_ROI_START, 18'h3C000);  // negative region start
    write_reg(REG_ROI_END, 18'h1FFFF);
    for (int t = 0; t < 8; t++) begin
      write_reg(REG_TRANSFORM, t[2:0]);
      write_reg(REG_ROUNDING, t[2:0]);
      write_reg(REG_DOWNSAMPLE, t[0]);
      queue_coord(16'd1);
      queue_coord(16'd3);
      wait_idle();
    end

    // Zero scale, zero lengths and a huge scale: saturation and the
    // degenerate axes.
    write_reg(REG_TRANSFORM, XF_ASYMMETRIC);
    write_reg(REG_SCALE, 24'd0);
    queue_coord(16'hFFFF);
    wait_idle();
    write_reg(REG_TRANSFORM, XF_CROP);
    write_reg(REG_RESIZED, 17'd0);
    write_reg(REG_SOURCE, 17'd0);
    queue_coord(16'd7);
    wait_idle();
    write_reg(REG_RESIZED, 17'h1FFFF);
    write_reg(REG_SOURCE, 17'h1FFFF);
    write_reg(REG_ROI_START, 18'h20000);
    write_reg(REG_SCALE, 24'hFFFFFF);
    queue_coord(16'hFFFF);
    queue_coord(16'd0);
    wait_idle();
    write_reg(REG_TRANSFORM, XF_PYTORCH_HALF);
    queue_coord(16'd0);
    wait_idle();

    // Random phases. The first backs up the pipeline with a long hold-off.
    for (int phase = 0; phase < 12; phase++) begin
      random_setup();
      if (phase == 0) drain_hold = 1'b1;
      if (phase == 10) idle_free = 1'b1;
      for (int k = 0; k < RandItems / 12; k++)
        queue_coord(($urandom_range(0, 1)) ? 16'($urandom_range(0, 300))
                                           : 16'($urandom));
      wait_idle();
    end

    if (error_count == 0) begin
      $display("[resize_coordinate_mapper] OK");
    end else begin
      $display("[resize_coordinate_mapper] ERROR");
    end
    $finish;
  end

endmodule
